FILE: rtl/bbce_pkg.sv
`default_nettype none
package bbce_pkg;
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxRadius = 7;
  localparam int unsigned StoreRows = 16;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegRadius = 2'd2;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [15:0] row;
    logic [12:0] col;
    logic [15:0] h;
    logic [12:0] w;
    logic [3:0]  r;
    logic        last;
  } job_t;
endpackage
`default_nettype wire

FILE: rtl/bbce_ram.sv
`default_nettype none
module bbce_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/bbce_divider.sv
`default_nettype none
module bbce_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] num_i,
  input  wire logic [7:0]  den_i,
  output logic             done_o,
  output logic [7:0]       quot_o
);
  logic [15:0] num_q, num_d;
  logic [8:0]  rem_q, rem_d;
  logic [7:0]  den_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q;
  logic [9:0]  trial;
  logic [8:0]  shifted;

  always_comb begin
    shifted = {rem_q[7:0], num_q[15]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
    num_d   = {num_q[14:0], 1'b0};
    if (!trial[9]) begin
      rem_d    = trial[8:0];
      num_d[0] = 1'b1;
    end else begin
      rem_d = shifted;
    end
    cnt_d = cnt_q + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= busy_q && !start_i && (cnt_q == 5'd15);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_d;
        if (cnt_q == 5'd15) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = num_q[7:0];
endmodule
`default_nettype wire

FILE: rtl/bbce_front.sv
`default_nettype none
module bbce_front #(
  parameter int unsigned MaxWidth  = bbce_pkg::MaxWidth,
  parameter int unsigned MaxRadius = bbce_pkg::MaxRadius,
  parameter int unsigned StoreRows = bbce_pkg::StoreRows,
  localparam int unsigned Aw = $clog2(StoreRows) + $clog2(MaxWidth)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_valid_i,
  output logic             s_ready_o,
  input  wire logic        s_mode_i,
  input  wire logic [23:0] s_pixel_i,
  output logic             we_o,
  output logic [Aw-1:0]    waddr_o,
  output logic [23:0]      wdata_o,
  output logic             job_valid_o,
  input  wire logic        job_ready_i,
  input  wire logic        store_busy_i,
  output bbce_pkg::job_t   job_o
);
  localparam int unsigned RowBits = $clog2(StoreRows);
  localparam int unsigned ColBits = $clog2(MaxWidth);
  localparam int unsigned RLimA = MaxRadius;
  localparam int unsigned RLimB = (StoreRows - 2) / 2;
  localparam int unsigned RLim  = (RLimA < RLimB) ? RLimA : RLimB;

  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [2:0]  radius_q;
  logic [16:0] in_row_q;
  logic [12:0] in_col_q;
  logic [15:0] out_row_q;
  logic [12:0] out_col_q;
  logic [12:0] w;
  logic [15:0] h;
  logic [3:0]  r;
  logic        push, full, ready, last;
  logic [16:0] in_row_n;
  logic [12:0] in_col_n;
  logic [16:0] need_row;
  logic [13:0] need_col;

  always_comb begin
    w = {2'b00, width_q};
    if (width_q == 11'd0) w = 13'd1;
    if ({2'b00, width_q} > 13'(MaxWidth)) w = 13'(MaxWidth);
    h = (height_q == 16'd0) ? 16'd1 : height_q;
    r = {1'b0, radius_q};
    if ({1'b0, radius_q} > 4'(RLim)) r = 4'(RLim);
  end

  // hold items while a queued or running job still reads the line store
  assign s_ready_o   = job_ready_i && !store_busy_i;
  assign cfg_ready_o = 1'b1;
  assign full = in_row_q >= {1'b0, h};
  assign push = s_valid_i && s_ready_o && !s_mode_i && !full;

  always_comb begin
    in_row_n = in_row_q;
    in_col_n = in_col_q;
    if (push) begin
      in_col_n = in_col_q + 13'd1;
      if (in_col_n >= w) begin
        in_col_n = '0;
        in_row_n = in_row_q + 17'd1;
      end
    end
    need_row = {1'b0, out_row_q} + 17'(r);
    if (need_row > {1'b0, h - 16'd1}) need_row = {1'b0, h - 16'd1};
    need_col = {1'b0, out_col_q} + 14'(r);
    if (need_col > {1'b0, w - 13'd1}) need_col = {1'b0, w - 13'd1};
    ready = (in_row_n >= {1'b0, h}) || (in_row_n > need_row) ||
            (in_row_n == need_row && {1'b0, in_col_n} > need_col);
    last = (out_row_q == h - 16'd1) && (out_col_q == w - 13'd1);
  end

  assign we_o    = push;
  assign waddr_o = Aw'({in_row_q[RowBits-1:0], in_col_q[ColBits-1:0]});
  assign wdata_o = s_pixel_i;
  assign job_valid_o = s_valid_i && s_ready_o && ready;
  assign job_o = '{row: out_row_q, col: out_col_q, h: h, w: w, r: r, last: last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 11'd1024;
      height_q  <= 16'd1;
      radius_q  <= 3'd1;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (cfg_valid_i && cfg_index_i inside
                 {bbce_pkg::RegWidth, bbce_pkg::RegHeight, bbce_pkg::RegRadius}) begin
      unique case (cfg_index_i)
        bbce_pkg::RegWidth:  width_q  <= cfg_data_i[10:0];
        bbce_pkg::RegHeight: height_q <= cfg_data_i;
        bbce_pkg::RegRadius: radius_q <= cfg_data_i[2:0];
        default: ;
      endcase
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
    end else if (s_valid_i && s_ready_o) begin
      if (ready && last) begin
        in_row_q  <= '0;
        in_col_q  <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
      end else begin
        in_row_q <= in_row_n;
        in_col_q <= in_col_n;
        if (ready) begin
          if (out_col_q + 13'd1 >= w) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + 16'd1;
          end else begin
            out_col_q <= out_col_q + 13'd1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/bbce_back.sv
`default_nettype none
module bbce_back #(
  parameter int unsigned MaxWidth  = bbce_pkg::MaxWidth,
  parameter int unsigned StoreRows = bbce_pkg::StoreRows,
  localparam int unsigned Aw = $clog2(StoreRows) + $clog2(MaxWidth)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  output logic             job_ready_o,
  input  bbce_pkg::job_t   job_i,
  output logic [Aw-1:0]    raddr_o,
  input  wire logic [23:0] rdata_i,
  output logic             rd_busy_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output logic [23:0]      m_pixel_o,
  output logic             m_last_o
);
  localparam int unsigned RowBits = $clog2(StoreRows);
  localparam int unsigned ColBits = $clog2(MaxWidth);

  typedef enum logic [2:0] {StIdle, StRead, StTail, StDiv, StOut} state_e;

  state_e          state_q;
  bbce_pkg::job_t  job_q;
  logic signed [5:0] dy_q, dx_q;
  logic [15:0] sum_q [3];
  logic        pend_q, tail_q;
  logic [1:0]  ch_q;
  logic [7:0]  count_q;
  logic [7:0]  res_q [3];
  logic signed [17:0] yy, xx;
  logic [15:0] y;
  logic [12:0] x;
  logic        div_start, div_done;
  logic [7:0]  div_q;

  assign job_ready_o = (state_q == StIdle);
  assign rd_busy_o   = (state_q == StRead);

  always_comb begin
    yy = $signed({2'b00, job_q.row}) + 18'(dy_q);
    xx = $signed({5'b0, job_q.col}) + 18'(dx_q);
    if (yy < 0) y = '0;
    else if (yy >= $signed({2'b00, job_q.h})) y = job_q.h - 16'd1;
    else y = yy[15:0];
    if (xx < 0) x = '0;
    else if (xx >= $signed({5'b0, job_q.w})) x = job_q.w - 13'd1;
    else x = xx[12:0];
  end

  assign raddr_o = Aw'({y[RowBits-1:0], x[ColBits-1:0]});
  assign div_start = (state_q == StDiv) && !pend_q;

  bbce_divider u_div (
    .clk_i,
    .rst_ni,
    .start_i(div_start),
    .num_i  (sum_q[ch_q]),
    .den_i  (count_q),
    .done_o (div_done),
    .quot_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      m_valid_o <= 1'b0;
      pend_q    <= 1'b0;
      tail_q    <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            dy_q    <= -$signed({2'b00, job_i.r});
            dx_q    <= -$signed({2'b00, job_i.r});
            sum_q   <= '{default: '0};
            tail_q  <= 1'b0;
            count_q <= 8'(({4'b0, job_i.r[2:0], 1'b1}) * ({4'b0, job_i.r[2:0], 1'b1}));
            state_q <= StRead;
          end
        end
        StRead: begin
          if (tail_q) begin
            sum_q[0] <= sum_q[0] + 16'(rdata_i[7:0]);
            sum_q[1] <= sum_q[1] + 16'(rdata_i[15:8]);
            sum_q[2] <= sum_q[2] + 16'(rdata_i[23:16]);
          end
          tail_q <= 1'b1;
          if (dx_q == $signed({2'b00, job_q.r})) begin
            dx_q <= -$signed({2'b00, job_q.r});
            if (dy_q == $signed({2'b00, job_q.r})) state_q <= StTail;
            else dy_q <= dy_q + 6'sd1;
          end else begin
            dx_q <= dx_q + 6'sd1;
          end
        end
        StTail: begin
          sum_q[0] <= sum_q[0] + 16'(rdata_i[7:0]);
          sum_q[1] <= sum_q[1] + 16'(rdata_i[15:8]);
          sum_q[2] <= sum_q[2] + 16'(rdata_i[23:16]);
          ch_q    <= '0;
          pend_q  <= 1'b0;
          state_q <= StDiv;
        end
        StDiv: begin
          if (!pend_q) begin
            pend_q <= 1'b1;
          end else if (div_done) begin
            res_q[ch_q] <= div_q;
            pend_q      <= 1'b0;
            if (ch_q == 2'd2) begin
              state_q <= StOut;
            end else begin
              ch_q <= ch_q + 2'd1;
            end
          end
        end
        StOut: begin
          if (!m_valid_o || m_ready_i) begin
            m_valid_o <= 1'b1;
            m_pixel_o <= {res_q[2], res_q[1], res_q[0]};
            m_last_o  <= job_q.last;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (m_valid_o && m_ready_i && !(state_q == StOut)) m_valid_o <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/bbce_queue.sv
`default_nettype none
module bbce_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  bbce_pkg::job_t  in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output bbce_pkg::job_t  out_o
);
  bbce_pkg::job_t mem_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic       push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_o = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_i;
  end
endmodule
`default_nettype wire

FILE: rtl/box_blur_clamped_edges.sv
// box blur with clamped borders, rgb stream in raster order
// s_axis: one item per pixel push (tuser = mode, 0 push / 1 drain tick),
//   tdata = red, green, blue from bit 0 up
// m_axis: one item per output pixel, tlast on the last pixel of the frame
// cfg: index 0 width, 1 height, 2 radius; writes restart the frame
// each output reads its (2r+1)^2 window from the line store one pixel a
//   cycle, then runs three serial divides, one per colour channel; the
//   window engine takes its next job only after that output is registered
// input is held while a job waits in the queue or the window engine is
//   reading the line store, so an item that starts an output holds back
//   the next item until that output's window has been read; other items
//   can follow back to back
// a full output register holds while the receiver stalls; one more job can
//   then wait in the queue before the input stalls as well
// reset clears the counters and restores width 1024, height 1, radius 1;
//   the line store needs no clearing
`default_nettype none
module box_blur_clamped_edges #(
  parameter int unsigned MaxWidth  = bbce_pkg::MaxWidth,
  parameter int unsigned MaxRadius = bbce_pkg::MaxRadius,
  parameter int unsigned StoreRows = bbce_pkg::StoreRows
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // red, green, blue
  input  wire logic        s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // out_red, out_green, out_blue
  output logic             m_axis_tlast   // frame_last
);
  localparam int unsigned Aw = $clog2(StoreRows) + $clog2(MaxWidth);

  logic          we;
  logic [Aw-1:0] waddr, raddr;
  logic [23:0]   wdata, rdata;
  logic          fj_valid, fj_ready, bj_valid, bj_ready;
  logic          rd_busy, store_busy;
  bbce_pkg::job_t fj, bj;

  assign store_busy = bj_valid || rd_busy;

  bbce_front #(.MaxWidth(MaxWidth), .MaxRadius(MaxRadius), .StoreRows(StoreRows)) u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready),
    .s_mode_i(s_axis_tuser), .s_pixel_i(s_axis_tdata),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata),
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .store_busy_i(store_busy),
    .job_o(fj)
  );

  bbce_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i(fj_valid), .in_ready_o(fj_ready), .in_i(fj),
    .out_valid_o(bj_valid), .out_ready_i(bj_ready), .out_o(bj)
  );

  bbce_ram #(.Width(24), .Depth(2 ** Aw)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  bbce_back #(.MaxWidth(MaxWidth), .StoreRows(StoreRows)) u_back (
    .clk_i, .rst_ni, .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj),
    .raddr_o(raddr), .rdata_i(rdata), .rd_busy_o(rd_busy),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_pixel_o(m_axis_tdata), .m_last_o(m_axis_tlast)
  );
endmodule
`default_nettype wire
